### src/running_median_keeper_unit_defines.svh
// assertion macros for the checks in this block
`ifndef RUNNING_MEDIAN_KEEPER_UNIT_DEFINES_SVH
`define RUNNING_MEDIAN_KEEPER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RMK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RMK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rmk_pkg.sv
package rmk_pkg;

    localparam int unsigned CAP     = 64;
    localparam int unsigned IDX_W   = $clog2(CAP);
    localparam int unsigned CNT_W   = $clog2(CAP + 1);
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;

    // broadcast from the controller to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             rem;
        t_data            key;
        logic [IDX_W-1:0] med_idx;
        logic [CNT_W-1:0] count;
    } t_cmd;

endpackage

### src/rmk_if.sv
interface rmk_in_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    rmk_pkg::t_data       value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface rmk_out_if;
    logic                          valid;
    logic                          ready;
    rmk_pkg::t_data                median;
    logic [rmk_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
    logic                          error;

    modport source (output valid, output median, output count, output is_empty,
                    output error, input ready);
    modport sink (input valid, input median, input count, input is_empty,
                  input error, output ready);
endinterface

### src/running_median_keeper_unit.sv
// running median keeper: holds up to 64 signed 32-bit values in a sorted row of
// compare-and-shift cells and returns, for every input transaction, the lower median
// (rank floor((n-1)/2)), the count held, an empty flag and an error flag. kind 0 inserts
// value; kind 1 removes the current lower median. an insert into a full row or a removal
// from an empty one changes nothing and sets error. each transaction runs in order: first
// every cell compares against the key (insert) or the median index (removal) and shifts
// with its neighbor, then the median cell is picked out of the row by an and-or reduction
// into the output register. a new transaction is not accepted until the previous one has
// been gathered and the output side takes results; the output register lets a new one be
// accepted in the same cycle the previous result is taken. no clearing pass is needed after reset.
`include "running_median_keeper_unit_defines.svh"

module running_median_keeper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmk_in_if.sink     i_in,
    rmk_out_if.source  o_out
);

    localparam int unsigned LP_CAP     = rmk_pkg::CAP;
    localparam int unsigned LP_IDX_W   = rmk_pkg::IDX_W;
    localparam int unsigned LP_CNT_W   = rmk_pkg::CNT_W;
    localparam int unsigned LP_COUNT_W = rmk_pkg::COUNT_W;

    // one-hot controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_GATHER = 2'b10
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [LP_CNT_W-1:0]     r_count;
    logic                    r_err;
    logic                    r_out_valid;
    rmk_pkg::t_data          r_out_median;
    logic [LP_COUNT_W-1:0]   r_out_count;
    logic                    r_out_empty;
    logic                    r_out_err;

    logic                    w_fire;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_do_ins;
    logic                    w_do_rem;
    logic                    w_req_err;
    logic [LP_CNT_W-1:0]     w_cnt_m1;
    logic [LP_CNT_W-1:0]     w_half;
    rmk_pkg::t_cmd           w_cmd;
    rmk_pkg::t_data          w_red;

    rmk_pkg::t_data          w_val  [LP_CAP];
    logic                    w_gt   [LP_CAP];
    rmk_pkg::t_data          w_part [LP_CAP];

    // handshake: new work only out of reset, when idle and the output slot is free by the
    // next edge
    assign i_in.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_full  = r_count == LP_CNT_W'(LP_CAP);
    assign w_empty = r_count == '0;

    assign w_do_ins  = w_fire && (i_in.kind == rmk_pkg::KIND_INSERT) && !w_full;
    assign w_do_rem  = w_fire && (i_in.kind == rmk_pkg::KIND_REMOVE) && !w_empty;
    assign w_req_err = (i_in.kind == rmk_pkg::KIND_INSERT) ? w_full : w_empty;

    // median index from the current count: removal point before the update,
    // selection point after it
    assign w_cnt_m1 = r_count - LP_CNT_W'(1);
    assign w_half   = w_cnt_m1 >> 1;

    always_comb begin
        w_cmd.ins     = w_do_ins;
        w_cmd.rem     = w_do_rem;
        w_cmd.key     = i_in.value;
        w_cmd.med_idx = w_half[LP_IDX_W-1:0];
        w_cmd.count   = r_count;
    end

    // the cell row: each cell sees its left neighbor for inserts and its right one for removals
    for (genvar g = 0; g < LP_CAP; g++) begin : g_cell
        rmk_pkg::t_data w_left_val;
        logic           w_left_gt;
        rmk_pkg::t_data w_right_val;

        if (g == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == LP_CAP - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        rmk_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (LP_IDX_W'(g)),
            .i_cmd       (w_cmd),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g]),
            .o_part      (w_part[g])
        );
    end

    // only the median cell drives a nonzero part, so an or across the row selects it
    always_comb begin
        w_red = '0;
        for (int i = 0; i < LP_CAP; i++) begin
            w_red = w_red | w_part[i];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_do_ins) begin
                r_count <= r_count + LP_CNT_W'(1);
            end else if (w_do_rem) begin
                r_count <= r_count - LP_CNT_W'(1);
            end
            if (r_state == S_GATHER) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_err <= w_req_err;
        end
        if (r_state == S_GATHER) begin
            r_out_median <= w_empty ? '0 : w_red;
            r_out_count  <= LP_COUNT_W'(r_count);
            r_out_empty  <= w_empty;
            r_out_err    <= r_err;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.median   = r_out_median;
    assign o_out.count    = r_out_count;
    assign o_out.is_empty = r_out_empty;
    assign o_out.error    = r_out_err;

    // a clean insert grows the row by exactly one
    `RMK_ASSERT_NEXT(a_ins_count, w_do_ins, r_count == $past(r_count) + LP_CNT_W'(1), "insert count")
    // removal error flags exactly an empty row
    `RMK_ASSERT_NEXT(a_rem_err, w_fire && (i_in.kind == rmk_pkg::KIND_REMOVE), r_err == ($past(r_count) == '0), "remove error")
    // the output slot is always free when the gather cycle loads it
    `RMK_ASSERT_NOW(a_gather_free, r_state == S_GATHER, !r_out_valid, "output overwrite")
    // an empty row reports a zero median
    `RMK_ASSERT_NOW(a_empty_zero, r_out_valid && r_out_empty, r_out_median == '0 && r_out_count == '0, "empty median")

endmodule

### src/rmk_cell.sv
module rmk_cell (
    input  logic                       i_clk,
    input  logic [rmk_pkg::IDX_W-1:0]  i_idx,
    input  rmk_pkg::t_cmd              i_cmd,
    input  rmk_pkg::t_data             i_left_val,
    input  logic                       i_left_gt,
    input  rmk_pkg::t_data             i_right_val,
    output rmk_pkg::t_data             o_val,
    output logic                       o_gt,
    output rmk_pkg::t_data             o_part
);

    localparam int unsigned LP_CNT_W = rmk_pkg::CNT_W;

    rmk_pkg::t_data r_val;
    rmk_pkg::t_data n_val;
    logic           w_occupied;

    // empty cells act as +infinity so the insert point is the first greater-or-empty cell
    assign w_occupied = LP_CNT_W'(i_idx) < i_cmd.count;
    assign o_gt       = !w_occupied || (r_val > i_cmd.key);

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (o_gt) begin
                n_val = i_left_gt ? i_left_val : i_cmd.key;
            end
        end else if (i_cmd.rem) begin
            if (i_idx >= i_cmd.med_idx) begin
                n_val = i_right_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_part = (i_idx == i_cmd.med_idx) ? r_val : '0;

endmodule
